/* design/rb2d_pkg.sv */
// Shared types and constants for the 2D rigid-body integrator.
package rb2d_pkg;

   localparam int RB2D_FRAC_BITS  = 16;
   localparam int RB2D_WORD_WIDTH = 32;

   localparam int FIELD_W   = 32;  // external signed fields
   localparam int DT_W      = 17;  // timestep field
   localparam int REG_W     = 31;  // mass and inertia registers
   localparam int CSR_IDX_W = 3;
   localparam int DIGIT_W   = 16;  // multiplier digit per cycle

   localparam logic [REG_W-1:0] MASS_RESET    = REG_W'(65536);
   localparam logic [REG_W-1:0] INERTIA_RESET = REG_W'(65536);

   localparam int FRIC_LIN = 35;
   localparam int FRIC_ANG = 15;

   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_FORCE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_KINEMATIC = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASS      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INERTIA   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_X  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_Y  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY_X = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY_Y = 3'd6;

   typedef enum logic {
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef enum logic [1:0] {
      ALU_IDLE,
      ALU_RUN,
      ALU_DONE,
      ALU_OUT
   } alu_state_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_POS_X,
      ST_POS_Y,
      ST_ANGLE,
      ST_FRIC_SUB,
      ST_FRIC_ADD,
      ST_GRAV_X1,
      ST_GRAV_X2,
      ST_GRAV_Y1,
      ST_GRAV_Y2,
      ST_DIV_X,
      ST_DIV_Y,
      ST_ARM,
      ST_SCALE_X,
      ST_SCALE_Y,
      ST_TORQ_1,
      ST_TORQ_2,
      ST_TORQ,
      ST_DIV_W,
      ST_RESP
   } seq_state_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctrl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } alu_stat_type;

endpackage

/* design/rb2d_alu.sv */
// Shared iterative multiply / divide unit with saturating fixed-point result.
module rb2d_alu import rb2d_pkg::*; #(
   parameter int FRAC_BITS  = RB2D_FRAC_BITS,
   parameter int WORD_WIDTH = RB2D_WORD_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  alu_ctrl_type                 ctrl,
   input  logic signed [WORD_WIDTH-1:0] op_a,
   input  logic signed [((WORD_WIDTH > FIELD_W) ? WORD_WIDTH : FIELD_W)-1:0] op_b,
   output alu_stat_type                 stat,
   output logic signed [WORD_WIDTH-1:0] result
);

   localparam int W    = WORD_WIDTH;
   localparam int MB   = (W > FIELD_W) ? W : FIELD_W;
   localparam int NDIG = (MB + DIGIT_W - 1) / DIGIT_W;
   localparam int BP   = NDIG * DIGIT_W;
   localparam int XW   = W + BP;
   localparam int NB   = W + FRAC_BITS;
   localparam int CW   = $clog2(NB + 1);

   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic [XW-1:0] LIM_NEG = XW'(1) << (W - 1);
   localparam logic [XW-1:0] LIM_POS = LIM_NEG - XW'(1);

   alu_state_type        state_ff, state_in;
   alu_op_type           op_ff, op_in;
   logic                 neg_ff, neg_in;
   logic                 zero_ff, zero_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [W-1:0]         a_mag_ff, a_mag_in;
   logic [BP-1:0]        b_sh_ff, b_sh_in;
   logic [REG_W-1:0]     div_ff, div_in;
   logic [REG_W-1:0]     rem_ff, rem_in;
   logic [XW-1:0]        work_ff, work_in;
   logic signed [W-1:0]  result_ff, result_in;

   logic [W-1:0]         a_abs;
   logic [MB-1:0]        b_abs;
   logic [W+DIGIT_W-1:0] pp;
   logic [REG_W:0]       rem_sh;
   logic                 ge;
   logic [XW-1:0]        mag_x;
   logic [W-1:0]         mag_w;
   logic                 over;

   assign a_abs = op_a[W-1] ? W'(-op_a) : W'(op_a);
   assign b_abs = op_b[MB-1] ? MB'(-op_b) : MB'(op_b);

   assign pp     = a_mag_ff * b_sh_ff[BP-1 -: DIGIT_W];
   assign rem_sh = {rem_ff, work_ff[NB-1]};
   assign ge     = rem_sh >= {1'b0, div_ff};

   assign mag_x = (op_ff == ALU_MUL) ? (work_ff >> FRAC_BITS) : work_ff;
   assign mag_w = mag_x[W-1:0];
   assign over  = mag_x > (neg_ff ? LIM_NEG : LIM_POS);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ALU_IDLE: if (ctrl.start) state_in = ALU_RUN;
         ALU_RUN:  if (cnt_ff == CW'(1)) state_in = ALU_DONE;
         ALU_DONE: state_in = ALU_OUT;
         ALU_OUT:  state_in = ALU_IDLE;
         default:  state_in = ALU_IDLE;
      endcase
   end

   // status outputs
   always_comb begin
      stat.idle = 1'b0;
      stat.done = 1'b0;
      unique case (state_ff)
         ALU_IDLE: stat.idle = 1'b1;
         ALU_OUT:  stat.done = 1'b1;
         default:  stat.idle = 1'b0;
      endcase
   end

   // datapath
   always_comb begin
      op_in     = op_ff;
      neg_in    = neg_ff;
      zero_in   = zero_ff;
      cnt_in    = cnt_ff;
      a_mag_in  = a_mag_ff;
      b_sh_in   = b_sh_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      work_in   = work_ff;
      result_in = result_ff;
      unique case (state_ff)
         ALU_IDLE: begin
            if (ctrl.start) begin
               op_in    = ctrl.op;
               a_mag_in = a_abs;
               b_sh_in  = BP'(b_abs);
               div_in   = op_b[REG_W-1:0];
               rem_in   = '0;
               zero_in  = (op_a == '0);
               if (ctrl.op == ALU_MUL) begin
                  neg_in  = op_a[W-1] ^ op_b[MB-1];
                  cnt_in  = CW'(NDIG);
                  work_in = '0;
               end else begin
                  neg_in  = op_a[W-1];
                  cnt_in  = CW'(NB);
                  work_in = XW'(a_abs) << FRAC_BITS;
               end
            end
         end
         ALU_RUN: begin
            cnt_in = cnt_ff - CW'(1);
            if (op_ff == ALU_MUL) begin
               // Horner over digits, most significant digit first
               work_in = (work_ff << DIGIT_W) + XW'(pp);
               b_sh_in = b_sh_ff << DIGIT_W;
            end else begin
               // restoring step: one quotient bit into the bottom
               rem_in  = ge ? REG_W'(rem_sh - {1'b0, div_ff}) : REG_W'(rem_sh);
               work_in = XW'({work_ff[NB-2:0], ge});
            end
         end
         ALU_DONE: begin
            if (zero_ff) begin
               result_in = '0;
            end else if (over) begin
               result_in = neg_ff ? WMIN : WMAX;
            end else begin
               result_in = neg_ff ? -mag_w : mag_w;
            end
         end
         default: begin
            result_in = result_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ALU_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      neg_ff    <= neg_in;
      zero_ff   <= zero_in;
      cnt_ff    <= cnt_in;
      a_mag_ff  <= a_mag_in;
      b_sh_ff   <= b_sh_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      work_ff   <= work_in;
      result_ff <= result_in;
   end

   assign result = result_ff;

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      stat.done |=> !stat.done)
      else $error("alu done held for more than one cycle");

   a_run_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ALU_RUN) |-> (cnt_ff != '0))
      else $error("alu iterating with an empty count");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (stat.done && zero_ff) |-> (result == '0))
      else $error("zero operand gave a nonzero result");

endmodule

/* design/rigid_body_2d_step.sv */
// Steps: a tick runs the position, angle and friction steps, then, for a body that is not
//   kinematic, the gravity, velocity and torque steps; a force request runs the velocity and
//   torque steps, or goes straight to the response for a kinematic body, and the response may
//   wait for the response register. The shared unit divides at one quotient bit per cycle.
// Throughput: one request at a time, the next taken once the response is loaded.
// Reset (synchronous, active high): body state and the other configuration registers clear to
//   zero, mass and inertia to 1.0 at the default FRAC_BITS, and no response is pending.
module rigid_body_2d_step import rb2d_pkg::*; #(
   parameter int FRAC_BITS  = RB2D_FRAC_BITS,
   parameter int WORD_WIDTH = RB2D_WORD_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   // configuration write port
   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [FIELD_W-1:0]          csr_wdata,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_kind,
   input  logic [DT_W-1:0]             req_dt,
   input  logic signed [FIELD_W-1:0]   req_force_x,
   input  logic signed [FIELD_W-1:0]   req_force_y,
   input  logic signed [FIELD_W-1:0]   req_point_x,
   input  logic signed [FIELD_W-1:0]   req_point_y,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [FIELD_W-1:0]   rsp_out_pos_x,
   output logic signed [FIELD_W-1:0]   rsp_out_pos_y,
   output logic signed [FIELD_W-1:0]   rsp_out_angle,
   output logic signed [FIELD_W-1:0]   rsp_out_vel_x,
   output logic signed [FIELD_W-1:0]   rsp_out_vel_y,
   output logic signed [FIELD_W-1:0]   rsp_out_spin
);

   localparam int W  = WORD_WIDTH;
   localparam int MB = (W > FIELD_W) ? W : FIELD_W;
   localparam int EW = MB;  // field conversion width

   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

   // 0.005 in the word's fixed-point format, rounded
   localparam int K_ARM = ((5 << FRAC_BITS) + 500) / 1000;

   // ------------------------------------------------------------------
   // Helpers: saturating add/subtract, field to word and word to field.
   // ------------------------------------------------------------------
   function automatic logic signed [W-1:0] sat_sum(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b,
                                                   input logic sub);
      logic signed [W:0] s;
      s = sub ? ((W+1)'(a) - (W+1)'(b)) : ((W+1)'(a) + (W+1)'(b));
      if (s[W] != s[W-1]) begin
         return s[W] ? WMIN : WMAX;
      end
      return s[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] to_word(input logic signed [FIELD_W-1:0] v);
      logic signed [EW-1:0] e;
      e = EW'(v);
      if (e > EW'(WMAX)) begin
         return WMAX;
      end
      if (e < EW'(WMIN)) begin
         return WMIN;
      end
      return e[W-1:0];
   endfunction

   function automatic logic signed [FIELD_W-1:0] to_field(input logic signed [W-1:0] v);
      logic signed [EW-1:0] e;
      e = EW'(v);
      return e[FIELD_W-1:0];
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic                kin_ff;
   logic [REG_W-1:0]    mass_ff, inertia_ff;
   logic signed [W-1:0] centre_x_ff, centre_y_ff, grav_x_ff, grav_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kin_ff      <= 1'b0;
         mass_ff     <= MASS_RESET;
         inertia_ff  <= INERTIA_RESET;
         centre_x_ff <= '0;
         centre_y_ff <= '0;
         grav_x_ff   <= '0;
         grav_y_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KINEMATIC: kin_ff      <= csr_wdata[0];
            CSR_MASS:      mass_ff     <= csr_wdata[REG_W-1:0];
            CSR_INERTIA:   inertia_ff  <= csr_wdata[REG_W-1:0];
            CSR_CENTRE_X:  centre_x_ff <= to_word(csr_wdata);
            CSR_CENTRE_Y:  centre_y_ff <= to_word(csr_wdata);
            CSR_GRAVITY_X: grav_x_ff   <= to_word(csr_wdata);
            CSR_GRAVITY_Y: grav_y_ff   <= to_word(csr_wdata);
            default:       kin_ff      <= kin_ff;  // unused index: drop the write
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Sequencer and body state
   // ------------------------------------------------------------------
   seq_state_type       state_ff, state_in;
   logic                issued_ff, issued_in;
   logic [DT_W-1:0]     dt_ff, dt_in;

   // Body state.
   logic signed [W-1:0] pos_x_ff, pos_x_in;
   logic signed [W-1:0] pos_y_ff, pos_y_in;
   logic signed [W-1:0] angle_ff, angle_in;
   logic signed [W-1:0] vel_x_ff, vel_x_in;
   logic signed [W-1:0] vel_y_ff, vel_y_in;
   logic signed [W-1:0] spin_ff, spin_in;

   // Scratch: force pair, then scaled force; arm pair, then torque terms.
   logic signed [W-1:0] fx_ff, fx_in;
   logic signed [W-1:0] fy_ff, fy_in;
   logic signed [W-1:0] px_ff, px_in;
   logic signed [W-1:0] py_ff, py_in;

   // Response holding register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [FIELD_W-1:0] out_pos_x_ff, out_pos_x_in;
   logic signed [FIELD_W-1:0] out_pos_y_ff, out_pos_y_in;
   logic signed [FIELD_W-1:0] out_angle_ff, out_angle_in;
   logic signed [FIELD_W-1:0] out_vel_x_ff, out_vel_x_in;
   logic signed [FIELD_W-1:0] out_vel_y_ff, out_vel_y_in;
   logic signed [FIELD_W-1:0] out_spin_ff, out_spin_in;

   alu_ctrl_type         alu_ctrl;
   alu_stat_type         alu_stat;
   logic signed [W-1:0]  alu_a;
   logic signed [MB-1:0] alu_b;
   logic signed [W-1:0]  alu_res;
   logic                 op_active;
   alu_op_type           op_sel;

   logic                 accept;
   logic                 rsp_free;
   logic signed [W-1:0]  fric_lin, fric_ang;

   assign accept   = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // friction amounts are exact multiples of dt and fit the word at the default widths
   assign fric_lin = W'(dt_ff) * W'(FRIC_LIN);
   assign fric_ang = W'(dt_ff) * W'(FRIC_ANG);

   rb2d_alu #(
      .FRAC_BITS  (FRAC_BITS),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (alu_ctrl),
      .op_a   (alu_a),
      .op_b   (alu_b),
      .stat   (alu_stat),
      .result (alu_res)
   );

   // Next state: arithmetic steps advance when the shared unit reports done,
   // the plain add steps advance every cycle.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_TICK) begin
                  state_in = ST_POS_X;
               end else begin
                  state_in = kin_ff ? ST_RESP : ST_DIV_X;
               end
            end
         end
         ST_POS_X:    if (alu_stat.done) state_in = ST_POS_Y;
         ST_POS_Y:    if (alu_stat.done) state_in = ST_ANGLE;
         ST_ANGLE:    if (alu_stat.done) state_in = ST_FRIC_SUB;
         ST_FRIC_SUB: state_in = ST_FRIC_ADD;
         ST_FRIC_ADD: state_in = kin_ff ? ST_RESP : ST_GRAV_X1;
         ST_GRAV_X1:  if (alu_stat.done) state_in = ST_GRAV_X2;
         ST_GRAV_X2:  if (alu_stat.done) state_in = ST_GRAV_Y1;
         ST_GRAV_Y1:  if (alu_stat.done) state_in = ST_GRAV_Y2;
         ST_GRAV_Y2:  if (alu_stat.done) state_in = ST_DIV_X;
         ST_DIV_X:    if (alu_stat.done) state_in = ST_DIV_Y;
         ST_DIV_Y:    if (alu_stat.done) state_in = ST_ARM;
         ST_ARM:      state_in = ST_SCALE_X;
         ST_SCALE_X:  if (alu_stat.done) state_in = ST_SCALE_Y;
         ST_SCALE_Y:  if (alu_stat.done) state_in = ST_TORQ_1;
         ST_TORQ_1:   if (alu_stat.done) state_in = ST_TORQ_2;
         ST_TORQ_2:   if (alu_stat.done) state_in = ST_TORQ;
         ST_TORQ:     state_in = ST_DIV_W;
         ST_DIV_W:    if (alu_stat.done) state_in = ST_RESP;
         ST_RESP:     if (rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Outputs: handshake and operand selection for the shared unit.
   always_comb begin
      op_active = 1'b0;
      op_sel    = ALU_MUL;
      alu_a     = '0;
      alu_b     = '0;
      unique case (state_ff)
         ST_POS_X: begin
            op_active = 1'b1;
            alu_a     = vel_x_ff;
            alu_b     = MB'(dt_ff);
         end
         ST_POS_Y: begin
            op_active = 1'b1;
            alu_a     = vel_y_ff;
            alu_b     = MB'(dt_ff);
         end
         ST_ANGLE: begin
            op_active = 1'b1;
            alu_a     = spin_ff;
            alu_b     = MB'(dt_ff);
         end
         ST_GRAV_X1: begin
            op_active = 1'b1;
            alu_a     = grav_x_ff;
            alu_b     = MB'(mass_ff);
         end
         ST_GRAV_X2: begin
            op_active = 1'b1;
            alu_a     = fx_ff;
            alu_b     = MB'(dt_ff);
         end
         ST_GRAV_Y1: begin
            op_active = 1'b1;
            alu_a     = grav_y_ff;
            alu_b     = MB'(mass_ff);
         end
         ST_GRAV_Y2: begin
            op_active = 1'b1;
            alu_a     = fy_ff;
            alu_b     = MB'(dt_ff);
         end
         ST_DIV_X: begin
            op_active = 1'b1;
            op_sel    = ALU_DIV;
            alu_a     = fx_ff;
            alu_b     = MB'(mass_ff);
         end
         ST_DIV_Y: begin
            op_active = 1'b1;
            op_sel    = ALU_DIV;
            alu_a     = fy_ff;
            alu_b     = MB'(mass_ff);
         end
         ST_SCALE_X: begin
            op_active = 1'b1;
            alu_a     = fx_ff;
            alu_b     = MB'(K_ARM);
         end
         ST_SCALE_Y: begin
            op_active = 1'b1;
            alu_a     = fy_ff;
            alu_b     = MB'(K_ARM);
         end
         ST_TORQ_1: begin
            op_active = 1'b1;
            alu_a     = px_ff;
            alu_b     = MB'(fy_ff);
         end
         ST_TORQ_2: begin
            op_active = 1'b1;
            alu_a     = py_ff;
            alu_b     = MB'(fx_ff);
         end
         ST_DIV_W: begin
            op_active = 1'b1;
            op_sel    = ALU_DIV;
            alu_a     = py_ff;
            alu_b     = MB'(inertia_ff);
         end
         default: begin
            op_active = 1'b0;
         end
      endcase
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign alu_ctrl.start = op_active && !issued_ff;
   assign alu_ctrl.op    = op_sel;

   // Datapath: capture the request, commit each step's result, load the response.
   always_comb begin
      dt_in        = dt_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      angle_in     = angle_ff;
      vel_x_in     = vel_x_ff;
      vel_y_in     = vel_y_ff;
      spin_in      = spin_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_pos_x_in = out_pos_x_ff;
      out_pos_y_in = out_pos_y_ff;
      out_angle_in = out_angle_ff;
      out_vel_x_in = out_vel_x_ff;
      out_vel_y_in = out_vel_y_ff;
      out_spin_in  = out_spin_ff;

      // hold the issue flag until the unit answers
      if (alu_stat.done) begin
         issued_in = 1'b0;
      end else begin
         issued_in = issued_ff || alu_ctrl.start;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dt_in   = req_dt;
               if (req_kind == KIND_TICK) begin
                  // gravity acts at the mass centre, so the arm is zero
                  px_in = centre_x_ff;
                  py_in = centre_y_ff;
               end else begin
                  fx_in = to_word(req_force_x);
                  fy_in = to_word(req_force_y);
                  px_in = to_word(req_point_x);
                  py_in = to_word(req_point_y);
               end
            end
         end
         ST_POS_X: if (alu_stat.done) pos_x_in = sat_sum(pos_x_ff, alu_res, 1'b0);
         ST_POS_Y: if (alu_stat.done) pos_y_in = sat_sum(pos_y_ff, alu_res, 1'b0);
         ST_ANGLE: if (alu_stat.done) angle_in = sat_sum(angle_ff, alu_res, 1'b0);
         ST_FRIC_SUB: begin
            if (vel_x_ff > 0) vel_x_in = sat_sum(vel_x_ff, fric_lin, 1'b1);
            if (vel_y_ff > 0) vel_y_in = sat_sum(vel_y_ff, fric_lin, 1'b1);
            if (spin_ff > 0)  spin_in  = sat_sum(spin_ff, fric_ang, 1'b1);
         end
         ST_FRIC_ADD: begin
            // a component below zero, also one pushed there by the subtract, gets the amount added
            if (vel_x_ff < 0) vel_x_in = sat_sum(vel_x_ff, fric_lin, 1'b0);
            if (vel_y_ff < 0) vel_y_in = sat_sum(vel_y_ff, fric_lin, 1'b0);
            if (spin_ff < 0)  spin_in  = sat_sum(spin_ff, fric_ang, 1'b0);
         end
         ST_GRAV_X1, ST_GRAV_X2, ST_SCALE_X: if (alu_stat.done) fx_in = alu_res;
         ST_GRAV_Y1, ST_GRAV_Y2, ST_SCALE_Y: if (alu_stat.done) fy_in = alu_res;
         ST_DIV_X: if (alu_stat.done) vel_x_in = sat_sum(vel_x_ff, alu_res, 1'b0);
         ST_DIV_Y: if (alu_stat.done) vel_y_in = sat_sum(vel_y_ff, alu_res, 1'b0);
         ST_ARM: begin
            px_in = sat_sum(centre_x_ff, px_ff, 1'b1);
            py_in = sat_sum(centre_y_ff, py_ff, 1'b1);
         end
         ST_TORQ_1: if (alu_stat.done) px_in = alu_res;
         ST_TORQ_2: if (alu_stat.done) py_in = alu_res;
         ST_TORQ:   py_in = sat_sum(px_ff, py_ff, 1'b1);
         ST_DIV_W:  if (alu_stat.done) spin_in = sat_sum(spin_ff, alu_res, 1'b0);
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               out_pos_x_in = to_field(pos_x_ff);
               out_pos_y_in = to_field(pos_y_ff);
               out_angle_in = to_field(angle_ff);
               out_vel_x_in = to_field(vel_x_ff);
               out_vel_y_in = to_field(vel_y_ff);
               out_spin_in  = to_field(spin_ff);
            end
         end
         default: begin
            dt_in = dt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         angle_ff     <= '0;
         vel_x_ff     <= '0;
         vel_y_ff     <= '0;
         spin_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         angle_ff     <= angle_in;
         vel_x_ff     <= vel_x_in;
         vel_y_ff     <= vel_y_in;
         spin_ff      <= spin_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff        <= dt_in;
      fx_ff        <= fx_in;
      fy_ff        <= fy_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      out_pos_x_ff <= out_pos_x_in;
      out_pos_y_ff <= out_pos_y_in;
      out_angle_ff <= out_angle_in;
      out_vel_x_ff <= out_vel_x_in;
      out_vel_y_ff <= out_vel_y_in;
      out_spin_ff  <= out_spin_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_pos_x = out_pos_x_ff;
   assign rsp_out_pos_y = out_pos_y_ff;
   assign rsp_out_angle = out_angle_ff;
   assign rsp_out_vel_x = out_vel_x_ff;
   assign rsp_out_vel_y = out_vel_y_ff;
   assign rsp_out_spin  = out_spin_ff;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      alu_ctrl.start |-> alu_stat.idle)
      else $error("operation issued while the shared unit is busy");

   a_done_in_op_step: assert property (@(posedge clock) disable iff (reset)
      alu_stat.done |-> op_active)
      else $error("shared unit answered outside an arithmetic step");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request taken while another is in progress");

   a_state_holds_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !accept) |=> ($stable(vel_x_ff) && $stable(spin_ff)))
      else $error("body state moved with no request in progress");

endmodule
